// File: sv/itod_pkg.sv
// Package for the integer to decimal ASCII converter.
// Holds sizing constants, character codes and the controller/datapath link types.
// No dependencies.
`default_nettype none
package itod_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int VALUE_BITS     = 32;
   localparam int DIGIT_COUNT    = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS       = DIGIT_COUNT * 4;
   localparam int BIT_CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIGIT_CNT_BITS = $clog2(DIGIT_COUNT + 1);
   localparam int CHAR_BITS      = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic load;
      logic shift;
      logic trim;
      logic emit_sign;
      logic emit_digit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bits_last;
      logic top_zero;
      logic digit_one;
      logic negative;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: sv/itod_if.sv
// Valid/ready channel interfaces for the converter's request and response beats.
// Depends on itod_pkg for field widths.
`default_nettype none
interface itod_req_if;
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic [itod_pkg::VALUE_WIDTH-1:0]   value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface itod_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [itod_pkg::CHAR_BITS-1:0]     character;
   logic                               last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: sv/integer_to_decimal_ascii.sv
// Integer to decimal ASCII converter: one request beat in, one response beat per
// character out, most significant first, last beat flagged. A request is taken
// only when the converter is idle; it is then loaded, shifted through the
// double-dabble registers in the datapath, stripped of leading zero digits (up
// to DIGIT_COUNT-1), and emitted one character at a time (sign, then up to
// DIGIT_COUNT digits), waiting whenever the response side is stalling. Trimmed
// and emitted digits always add up to DIGIT_COUNT. The final character waits in
// the output register while the next request is loaded.
// Depends on itod_pkg, itod_if, itod_ctrl and itod_dp.
`default_nettype none
module integer_to_decimal_ascii (
   input  wire logic     clock,
   input  wire logic     reset,
   itod_req_if.sink      req_ch,
   itod_rsp_if.source    rsp_ch
);

   itod_pkg::ctrl_cmd_type  cmd;
   itod_pkg::dp_status_type status;

   itod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   itod_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_ch.command),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_character (rsp_ch.character),
      .rsp_last      (rsp_ch.last)
   );

endmodule
`default_nettype wire

// File: sv/itod_ctrl.sv
// Sequencer for the converter: load, double-dabble, leading-zero trim, emission.
// Depends on itod_pkg.
`default_nettype none
module itod_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire itod_pkg::dp_status_type status,
   output itod_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (status.bits_last) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (status.top_zero && !status.digit_one) begin
               cmd.trim = 1'b1;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.digit_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/itod_dp.sv
// Datapath: magnitude, binary/BCD shift registers, digit count and output register.
// Depends on itod_pkg.
`default_nettype none
module itod_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire itod_pkg::ctrl_cmd_type              cmd,
   output itod_pkg::dp_status_type                  status,
   input  wire logic                                req_command,
   input  wire logic [itod_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [itod_pkg::CHAR_BITS-1:0]           rsp_character,
   output logic                                     rsp_last
);

   logic [itod_pkg::VALUE_BITS-1:0]     bin_ff, bin_in;
   logic [itod_pkg::BCD_BITS-1:0]       bcd_ff, bcd_in;
   logic [itod_pkg::BCD_BITS-1:0]       bcd_adj;
   logic [itod_pkg::BIT_CNT_BITS-1:0]   bitcnt_ff, bitcnt_in;
   logic [itod_pkg::DIGIT_CNT_BITS-1:0] ndig_ff, ndig_in;
   logic                                neg_ff, neg_in;
   logic                                valid_ff, valid_in;
   logic [itod_pkg::CHAR_BITS-1:0]      char_ff, char_in;
   logic                                last_ff, last_in;
   logic [itod_pkg::VALUE_BITS-1:0]     raw;
   logic [3:0]                          top_digit;
   logic                                digit_one;

   assign raw       = itod_pkg::VALUE_BITS'(req_value);
   assign top_digit = bcd_ff[itod_pkg::BCD_BITS-1 -: 4];
   assign digit_one = (ndig_ff == itod_pkg::DIGIT_CNT_BITS'(1));

   always_comb begin
      for (int i = 0; i < itod_pkg::DIGIT_COUNT; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      bitcnt_in = bitcnt_ff;
      ndig_in   = ndig_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff && !rsp_ready;
      char_in   = char_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         neg_in    = req_command && raw[itod_pkg::VALUE_BITS-1];
         bin_in    = neg_in ? (~raw + itod_pkg::VALUE_BITS'(1)) : raw;
         bcd_in    = '0;
         bitcnt_in = '0;
         ndig_in   = itod_pkg::DIGIT_CNT_BITS'(itod_pkg::DIGIT_COUNT);
      end
      if (cmd.shift) begin
         bcd_in    = {bcd_adj[itod_pkg::BCD_BITS-2:0], bin_ff[itod_pkg::VALUE_BITS-1]};
         bin_in    = bin_ff << 1;
         bitcnt_in = bitcnt_ff + itod_pkg::BIT_CNT_BITS'(1);
      end
      if (cmd.trim || cmd.emit_digit) begin
         bcd_in  = bcd_ff << 4;
         ndig_in = ndig_ff - itod_pkg::DIGIT_CNT_BITS'(1);
      end
      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = itod_pkg::CHAR_MINUS;
         last_in  = 1'b0;
      end
      if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = itod_pkg::CHAR_ZERO + {4'b0000, top_digit};
         last_in  = digit_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      bitcnt_ff <= bitcnt_in;
      ndig_ff   <= ndig_in;
      neg_ff    <= neg_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   always_comb begin
      status.bits_last = (bitcnt_ff == itod_pkg::BIT_CNT_BITS'(itod_pkg::VALUE_BITS - 1));
      status.top_zero  = (top_digit == 4'd0);
      status.digit_one = digit_one;
      status.negative  = neg_ff;
      status.out_free  = !valid_ff || rsp_ready;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire
